@@ design/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest: shared package
// Constants, transaction types and state codes used across the digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Compression rounds per block and width of the round counter.
  localparam int ROUNDS = 80;
  localparam int RND_W  = $clog2(ROUNDS);

  // Digest words per message and the index of the final one.
  localparam int          DIGEST_WORDS  = 5;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

  // Padding marker byte that follows the message.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Initial chaining values.
  localparam logic [31:0] IV_0 = 32'h67452301;
  localparam logic [31:0] IV_1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_2 = 32'h98BADCFE;
  localparam logic [31:0] IV_3 = 32'h10325476;
  localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  // Classified input transaction: a finish carries the padding marker byte.
  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COMP = 5'b00010,
    S_FOLD = 5'b00100,
    S_PAD  = 5'b01000,
    S_EMIT = 5'b10000
  } back_state_t;

  // Where the sequencer goes once a block has been folded in.
  typedef enum logic [1:0] {
    POST_IDLE = 2'd0,
    POST_PAD  = 2'd1,
    POST_EMIT = 2'd2
  } post_t;

  // Initial chaining word by index.
  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = IV_0;
      3'd1:    w = IV_1;
      3'd2:    w = IV_2;
      3'd3:    w = IV_3;
      default: w = IV_4;
    endcase
    return w;
  endfunction

endpackage

@@ design/sha1_message_digest_top.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest: top level
// Byte-stream SHA-1 with padding and a five-word digest output per message.
// ----------------------------------------------------------------------------
// Each absorb transaction adds one message byte; a finish transaction pads the
// message and returns the five digest words, word 0 first, the last marked.
// The back part takes one byte per cycle from a small queue while it is idle,
// and every full 64-byte block then goes through the 80-round compression and
// a fold; the front keeps taking bytes into the queue during compression until
// the queue fills. A finish shifts in the padding bytes, runs one or two
// compressions and then presents the five digest words, limited by the single
// round unit.
// ----------------------------------------------------------------------------
module sha1_message_digest_top #(
  parameter int QueueDepth = sha1md_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic                push;
  logic                pop;
  sha1md_pkg::item_t   push_item;
  sha1md_pkg::item_t   head_item;
  sha1md_pkg::q_stat_t q_stat;

  // Front part: input handshake and classification.
  sha1md_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  // Queue decoupling the two parts.
  sha1md_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  // Back part: buffering, padding, compression and output.
  sha1md_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_item       (head_item),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

@@ design/sha1md_front.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest: front part
// Takes input transactions, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module sha1md_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [7:0]          in_data_byte,
  input  sha1md_pkg::q_stat_t q_stat,
  output logic                push,
  output sha1md_pkg::item_t   push_item
);

  logic              hold_valid_r, hold_valid_nxt;
  sha1md_pkg::item_t hold_item_r,  hold_item_nxt;
  logic              accept;

  // The holding register drains into the queue whenever the queue has room.
  assign push      = hold_valid_r && !q_stat.full;
  assign push_item = hold_item_r;
  assign in_ready  = !hold_valid_r || !q_stat.full;
  assign accept    = in_valid && in_ready;

  // Classify: a finish is carried as the padding marker, absorb as its byte.
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_item_nxt  = hold_item_r;
    if (accept) begin
      hold_valid_nxt     = 1'b1;
      hold_item_nxt.fin  = in_op;
      hold_item_nxt.data = in_op ? sha1md_pkg::PAD_BYTE : in_data_byte;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_item_r <= hold_item_nxt;
  end

endmodule

@@ design/sha1md_queue.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest: transaction queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module sha1md_queue #(
  parameter int Depth = sha1md_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sha1md_pkg::item_t   push_item,
  input  logic                pop,
  output sha1md_pkg::item_t   head_item,
  output sha1md_pkg::q_stat_t q_stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sha1md_pkg::item_t  mem_r [Depth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    count_r,  count_nxt;

  assign q_stat.full  = (count_r == CntW'(Depth));
  assign q_stat.empty = (count_r == '0);
  assign head_item    = mem_r[rd_ptr_r];

  // Pointer and occupancy updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  // Occupancy never goes beyond the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("queue occupancy beyond depth");

  // A lone push raises the occupancy by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not follow a push");
`endif

endmodule

@@ design/sha1md_back.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest: back part
// Block buffer, padding sequencer, 80-round compression and digest output.
// ----------------------------------------------------------------------------
module sha1md_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1md_pkg::item_t   head_item,
  input  sha1md_pkg::q_stat_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);

  localparam int RndW = sha1md_pkg::RND_W;

  sha1md_pkg::back_state_t state_r, state_nxt;
  sha1md_pkg::post_t       post_r,  post_nxt;

  logic [RndW-1:0] rnd_r,       rnd_nxt;
  logic [5:0]      fill_r,      fill_nxt;
  logic [63:0]     bitlen_r,    bitlen_nxt;
  logic            final_blk_r, final_blk_nxt;
  logic [2:0]      emit_idx_r,  emit_idx_nxt;
  logic [511:0]    buf_r,       buf_nxt;
  logic [31:0]     a_r, b_r, c_r, d_r, e_r;
  logic [31:0]     a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0]     chain_r   [sha1md_pkg::DIGEST_WORDS];
  logic [31:0]     chain_nxt [sha1md_pkg::DIGEST_WORDS];

  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_word_r,  out_word_nxt;
  logic [2:0]      out_idx_r,   out_idx_nxt;
  logic            out_last_r,  out_last_nxt;

  logic [31:0]     w0, w2, w8, w13, w_new;
  logic [31:0]     f_val, k_val, t_val;
  logic [7:0]      pad_byte;
  logic            emit_load;
  logic            start_comp;

  // Boolean function of the round group.
  function automatic logic [31:0] round_f(input logic [RndW-1:0] r,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] f;
    if (r < RndW'(20)) begin
      f = (b & c) | (~b & d);
    end else if (r < RndW'(40)) begin
      f = b ^ c ^ d;
    end else if (r < RndW'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // Additive constant of the round group.
  function automatic logic [31:0] round_k(input logic [RndW-1:0] r);
    logic [31:0] k;
    if (r < RndW'(20)) begin
      k = sha1md_pkg::K_0;
    end else if (r < RndW'(40)) begin
      k = sha1md_pkg::K_1;
    end else if (r < RndW'(60)) begin
      k = sha1md_pkg::K_2;
    end else begin
      k = sha1md_pkg::K_3;
    end
    return k;
  endfunction

  // Schedule window: word j of the buffer holds w[t+j] during compression.
  assign w0    = buf_r[511:480];
  assign w2    = buf_r[447:416];
  assign w8    = buf_r[255:224];
  assign w13   = buf_r[95:64];
  assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                  (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

  // One compression round.
  assign f_val = round_f(rnd_r, b_r, c_r, d_r);
  assign k_val = round_k(rnd_r);
  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w0;

  // Padding byte: zeros, then the bit length big-endian in the final block.
  assign pad_byte = (final_blk_r && (fill_r[5:3] == 3'b111))
                  ? bitlen_r[{~fill_r[2:0], 3'b000} +: 8] : 8'h00;

  assign pop       = (state_r == sha1md_pkg::S_IDLE) && !q_stat.empty;
  assign emit_load = (state_r == sha1md_pkg::S_EMIT) && (!out_valid_r || out_ready);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    post_nxt      = post_r;
    rnd_nxt       = rnd_r;
    fill_nxt      = fill_r;
    bitlen_nxt    = bitlen_r;
    final_blk_nxt = final_blk_r;
    emit_idx_nxt  = emit_idx_r;
    buf_nxt       = buf_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    start_comp    = 1'b0;
    for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      sha1md_pkg::S_IDLE: begin
        if (pop) begin
          // Both kinds shift their byte in; a finish brings the marker.
          buf_nxt  = {buf_r[503:0], head_item.data};
          fill_nxt = fill_r + 1'b1;
          if (!head_item.fin) begin
            bitlen_nxt = bitlen_r + 64'd8;
            if (fill_r == 6'd63) begin
              start_comp = 1'b1;
              post_nxt   = sha1md_pkg::POST_IDLE;
            end
          end else if (fill_r == 6'd63) begin
            start_comp    = 1'b1;
            post_nxt      = sha1md_pkg::POST_PAD;
            final_blk_nxt = 1'b1;
          end else begin
            state_nxt     = sha1md_pkg::S_PAD;
            final_blk_nxt = (fill_r < 6'd56);
          end
        end
      end
      sha1md_pkg::S_PAD: begin
        buf_nxt  = {buf_r[503:0], pad_byte};
        fill_nxt = fill_r + 1'b1;
        if (fill_r == 6'd63) begin
          start_comp    = 1'b1;
          post_nxt      = final_blk_r ? sha1md_pkg::POST_EMIT : sha1md_pkg::POST_PAD;
          final_blk_nxt = 1'b1;
        end
      end
      sha1md_pkg::S_COMP: begin
        a_nxt   = t_val;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        buf_nxt = {buf_r[479:0], w_new};
        if (rnd_r == RndW'(sha1md_pkg::ROUNDS - 1)) begin
          rnd_nxt   = '0;
          state_nxt = sha1md_pkg::S_FOLD;
        end else begin
          rnd_nxt = rnd_r + 1'b1;
        end
      end
      sha1md_pkg::S_FOLD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        case (post_r)
          sha1md_pkg::POST_PAD:  state_nxt = sha1md_pkg::S_PAD;
          sha1md_pkg::POST_EMIT: state_nxt = sha1md_pkg::S_EMIT;
          default:               state_nxt = sha1md_pkg::S_IDLE;
        endcase
      end
      sha1md_pkg::S_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_r[emit_idx_r];
          out_idx_nxt   = emit_idx_r;
          out_last_nxt  = (emit_idx_r == sha1md_pkg::LAST_WORD_IDX);
          if (emit_idx_r == sha1md_pkg::LAST_WORD_IDX) begin
            // Message done: state, fill, bit length and chaining words back to reset values.
            emit_idx_nxt = '0;
            fill_nxt     = '0;
            bitlen_nxt   = '0;
            state_nxt    = sha1md_pkg::S_IDLE;
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
              chain_nxt[i] = sha1md_pkg::iv_word(3'(i));
            end
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = sha1md_pkg::S_IDLE;
      end
    endcase

    // Working variables start from the chaining words.
    if (start_comp) begin
      state_nxt = sha1md_pkg::S_COMP;
      rnd_nxt   = '0;
      a_nxt     = chain_r[0];
      b_nxt     = chain_r[1];
      c_nxt     = chain_r[2];
      d_nxt     = chain_r[3];
      e_nxt     = chain_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1md_pkg::S_IDLE;
      post_r      <= sha1md_pkg::POST_IDLE;
      rnd_r       <= '0;
      fill_r      <= '0;
      bitlen_r    <= '0;
      final_blk_r <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
        chain_r[i] <= sha1md_pkg::iv_word(3'(i));
      end
    end else begin
      state_r     <= state_nxt;
      post_r      <= post_nxt;
      rnd_r       <= rnd_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      final_blk_r <= final_blk_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
    buf_r      <= buf_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

`ifndef ASSERT_OFF
  // The round counter stays within the 80 rounds.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1md_pkg::S_COMP) |-> (rnd_r < RndW'(sha1md_pkg::ROUNDS)))
    else $error("round counter out of range");

  // A fold follows only the last compression round.
  a_fold_after_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1md_pkg::S_FOLD) |->
      ($past(state_r) == sha1md_pkg::S_COMP) &&
      ($past(rnd_r) == RndW'(sha1md_pkg::ROUNDS - 1)))
    else $error("fold without a completed compression");

  // After the final word the message state is back at its initial values.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && (emit_idx_r == sha1md_pkg::LAST_WORD_IDX)) |=>
      (state_r == sha1md_pkg::S_IDLE) && (fill_r == '0) && (bitlen_r == '0) &&
      (chain_r[0] == sha1md_pkg::IV_0) && (chain_r[4] == sha1md_pkg::IV_4))
    else $error("message state not restored after digest");
`endif

endmodule

@@ tb/sv/sha1_message_digest_top_test.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest: self-checking testbench
// Streams byte messages into the digest block and checks every digest word
// against a behavioural SHA-1 model. A short table of directed transactions
// comes first, with known digests for the empty string, "a" and "abc". Random
// messages follow, with block-boundary lengths among them, random idling on
// both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module sha1_message_digest_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes on in_op.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Well-known digests used by the directed rows.
  localparam logic [159:0] SHA1_OF_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] SHA1_OF_A     = 160'h86f7e437faa5a7fce15d1ddcb9eaeaea377667b8;
  localparam logic [159:0] SHA1_OF_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  localparam int ITEM_TARGET      = 430;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 300;
  localparam int TIMEOUT_NS       = 1_000_000;
  localparam int DIRECTED_ROWS    = 18;

  // One directed transaction; known marks a row whose digest is typed in.
  typedef struct packed {
    logic         op;
    logic [7:0]   data;
    logic         known;
    logic [159:0] digest;
  } directed_row_t;

  // One expected digest word on the result channel.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = OP_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Behavioural digest state: chaining words, block buffer, fill and length.
  logic [31:0] chain_words [5];
  logic [7:0]  msg_block [64];
  logic [5:0]  fill_ptr;
  logic [63:0] bit_count;

  digest_word_t pending_words [$];

  int  mismatches = 0;
  int  words_checked = 0;
  int  items_sent = 0;
  int  messages_done = 0;
  int  bytes_sent = 0;
  int  longest_message = 0;
  int  holds_done = 0;
  bit  steady_run = 1'b0;
  bit  hold_request = 1'b0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_FINISH, 8'hA5, 1'b1, SHA1_OF_EMPTY},
    '{OP_FINISH, 8'h00, 1'b1, SHA1_OF_EMPTY},
    '{OP_ABSORB, 8'h61, 1'b0, 160'h0},
    '{OP_FINISH, 8'hFF, 1'b1, SHA1_OF_A},
    '{OP_ABSORB, 8'h61, 1'b0, 160'h0},
    '{OP_ABSORB, 8'h62, 1'b0, 160'h0},
    '{OP_ABSORB, 8'h63, 1'b0, 160'h0},
    '{OP_FINISH, 8'h5A, 1'b1, SHA1_OF_ABC},
    '{OP_ABSORB, 8'h00, 1'b0, 160'h0},
    '{OP_FINISH, 8'h00, 1'b0, 160'h0},
    '{OP_ABSORB, 8'hFF, 1'b0, 160'h0},
    '{OP_FINISH, 8'hFF, 1'b0, 160'h0},
    '{OP_ABSORB, 8'h00, 1'b0, 160'h0},
    '{OP_ABSORB, 8'hFF, 1'b0, 160'h0},
    '{OP_ABSORB, 8'h80, 1'b0, 160'h0},
    '{OP_ABSORB, 8'h7F, 1'b0, 160'h0},
    '{OP_ABSORB, 8'h01, 1'b0, 160'h0},
    '{OP_FINISH, 8'h3C, 1'b0, 160'h0}
  };

  sha1_message_digest_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Folds the current 64-byte block into the chaining words.
  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 80; i++) begin
      w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    e = chain_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = sha1md_pkg::K_0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K_1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1md_pkg::K_2;
      end else begin
        f = b ^ c ^ d;
        k = sha1md_pkg::K_3;
      end
      t = rotl32(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
  endfunction

  function automatic void sha1_restart();
    chain_words = '{sha1md_pkg::IV_0, sha1md_pkg::IV_1, sha1md_pkg::IV_2,
                    sha1md_pkg::IV_3, sha1md_pkg::IV_4};
    fill_ptr    = '0;
    bit_count   = '0;
  endfunction

  // Applies one accepted transaction; a finish returns the five-word digest.
  function automatic void sha1_predict(input logic op, input logic [7:0] data,
                                       output logic [159:0] digest, output bit emitted);
    int pos;
    digest  = '0;
    emitted = 1'b0;
    if (op == OP_ABSORB) begin
      msg_block[fill_ptr] = data;
      bit_count += 64'd8;
      fill_ptr  += 6'd1;
      if (fill_ptr == 6'd0) begin
        sha1_compress();
      end
    end else begin
      pos = fill_ptr;
      msg_block[pos] = sha1md_pkg::PAD_BYTE;
      pos++;
      // Not enough room for the length: pad out and compress an extra block.
      if (pos > 56) begin
        while (pos < 64) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        sha1_compress();
        pos = 0;
      end
      while (pos < 56) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) begin
        msg_block[56+i] = bit_count[63-8*i -: 8];
      end
      sha1_compress();
      digest  = {chain_words[0], chain_words[1], chain_words[2],
                 chain_words[3], chain_words[4]};
      emitted = 1'b1;
      sha1_restart();
    end
  endfunction

  // Idle gap length: mostly none or short, occasionally long.
  function automatic int pick_idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Message length: mostly short, some around one block, a few of one to two blocks.
  function automatic int pick_message_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(0, 12);
    end else if (r < 92) begin
      return $urandom_range(13, 63);
    end
    return $urandom_range(64, 128);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Offers one transaction, waits for acceptance and records what it implies.
  task automatic send_item(input logic op, input logic [7:0] data, input logic known,
                           input logic [159:0] known_digest);
    int           idle;
    logic [159:0] digest;
    bit           emitted;
    idle = pick_idle_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    sha1_predict(op, data, digest, emitted);
    if (emitted) begin
      if (known) begin
        digest = known_digest;
      end
      for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
        pending_words.push_back('{digest[159-32*i -: 32], 3'(i),
                                  (3'(i) == sha1md_pkg::LAST_WORD_IDX)});
      end
      messages_done++;
    end else begin
      bytes_sent++;
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Result channel readiness, with random gaps and one long hold-off.
  initial begin : result_sink
    int idle;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end else begin
        idle = pick_idle_gap();
        if (idle > 0) begin
          out_ready <= 1'b0;
          repeat (idle) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // Each accepted digest word is compared with the oldest expectation.
  always @(posedge clk) begin : digest_monitor
    digest_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d",
                                  out_digest_word, out_word_index));
      end else begin
        exp_w = pending_words.pop_front();
        if (out_digest_word !== exp_w.word) begin
          report_mismatch($sformatf("word %0d: got %h, expected %h",
                                    exp_w.idx, out_digest_word, exp_w.word));
        end
        if (out_word_index !== exp_w.idx) begin
          report_mismatch($sformatf("word index: got %0d, expected %0d",
                                    out_word_index, exp_w.idx));
        end
        if (out_last_word !== exp_w.last) begin
          report_mismatch($sformatf("last flag on word %0d: got %b, expected %b",
                                    exp_w.idx, out_last_word, exp_w.last));
        end
        words_checked++;
      end
    end
  end

  // Reset, directed table, random messages, then drain and verdict.
  initial begin : stimulus
    int msg_len;
    int msg_idx;
    int boundary_lengths [3];
    boundary_lengths = '{55, 56, 64};
    sha1_restart();
    foreach (msg_block[i]) msg_block[i] = 8'h00;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].op, directed_rows[r].data,
                directed_rows[r].known, directed_rows[r].digest);
    end

    // Boundary lengths come first: the longest single-block message, the
    // shortest that needs an extra padding block, and an exactly full block.
    // A wrap of the bit-length counter would need 2^61 bytes and is out of reach.
    msg_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      msg_len    = (msg_idx < 3) ? boundary_lengths[msg_idx] : pick_message_length();
      // The last message is trimmed so the run ends near the item target.
      if (msg_len > ITEM_TARGET - items_sent - 1) msg_len = ITEM_TARGET - items_sent - 1;
      steady_run = (msg_idx % 5 == 4);
      for (int j = 0; j < msg_len; j++) begin
        send_item(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      send_item(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
      if (msg_len > longest_message) longest_message = msg_len;
      // Hold the result side while the next message keeps arriving.
      if (msg_idx == 1) hold_request = 1'b1;
      msg_idx++;
    end
    steady_run = 1'b0;
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions: %0d message bytes in %0d messages,",
             items_sent, bytes_sent, messages_done);
    $display("longest message %0d bytes, %0d digest words checked, %0d long hold-off(s).",
             longest_message, words_checked, holds_done);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d digest words still outstanding.", pending_words.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
